// ===== src/mrt_pkg.sv =====
// ----------------------------------------------------------------------------
// mrt_pkg
// Shared types and constants for the 4x4 matrix row transform unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mrt_pkg;

    localparam int ELEM_W     = 32;
    localparam int ROW_LEN    = 4;
    localparam int NUM_PAIRS  = 8;
    localparam int PAIR_W     = 2 * ELEM_W;
    localparam int CFG_IDX_W  = $clog2(NUM_PAIRS);
    localparam int CFG_DATA_W = PAIR_W;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int PSUM_W     = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 2;

    typedef struct packed {
        logic signed [ELEM_W-1:0] row_in_0;
        logic signed [ELEM_W-1:0] row_in_1;
        logic signed [ELEM_W-1:0] row_in_2;
        logic signed [ELEM_W-1:0] row_in_3;
    } row_in_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] row_out_0;
        logic signed [ELEM_W-1:0] row_out_1;
        logic signed [ELEM_W-1:0] row_out_2;
        logic signed [ELEM_W-1:0] row_out_3;
    } row_out_t;

    typedef logic [ROW_LEN-1:0][PROD_W-1:0] prod_vec_t;

    typedef struct packed {
        logic advance;
        logic valid;
    } mrt_ctrl_t;

endpackage

`default_nettype wire

// ===== src/mrt_lane.sv =====
// ----------------------------------------------------------------------------
// mrt_lane
// One input element times one row of B: four registered 32x32 products.
// ----------------------------------------------------------------------------
`default_nettype none

module mrt_lane
(
    input  wire logic                                   clk,
    input  wire logic                                   advance,
    input  wire logic signed [mrt_pkg::ELEM_W-1:0]      elem,
    input  wire logic [2*mrt_pkg::PAIR_W-1:0]           coef_row,
    output mrt_pkg::prod_vec_t                          prod
);

    mrt_pkg::prod_vec_t prod_reg;
    mrt_pkg::prod_vec_t prod_next;

    always_comb
    begin
        for (int j = 0; j < mrt_pkg::ROW_LEN; j++)
        begin
            prod_next[j] = mrt_pkg::PROD_W'(elem)
                         * mrt_pkg::PROD_W'($signed(coef_row[j*mrt_pkg::ELEM_W +: mrt_pkg::ELEM_W]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== src/mrt_merge.sv =====
// ----------------------------------------------------------------------------
// mrt_merge
// Sums the lane products per column, floors by the fraction bits, saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module mrt_merge
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mrt_pkg::mrt_ctrl_t   ctrl,
    input  wire mrt_pkg::prod_vec_t   lane_prod [mrt_pkg::ROW_LEN],
    output logic                      out_valid,
    output mrt_pkg::row_out_t         row_out
);

    localparam int HI_W = mrt_pkg::SUM_W - mrt_pkg::ELEM_W + 1;

    logic signed [mrt_pkg::PSUM_W-1:0] sum_a_reg  [mrt_pkg::ROW_LEN];
    logic signed [mrt_pkg::PSUM_W-1:0] sum_b_reg  [mrt_pkg::ROW_LEN];
    logic signed [mrt_pkg::PSUM_W-1:0] sum_a_next [mrt_pkg::ROW_LEN];
    logic signed [mrt_pkg::PSUM_W-1:0] sum_b_next [mrt_pkg::ROW_LEN];
    logic signed [mrt_pkg::SUM_W-1:0]  total      [mrt_pkg::ROW_LEN];
    logic signed [mrt_pkg::SUM_W-1:0]  shifted    [mrt_pkg::ROW_LEN];
    logic        [HI_W-1:0]            hi_bits    [mrt_pkg::ROW_LEN];
    logic        [mrt_pkg::ELEM_W-1:0] col_next   [mrt_pkg::ROW_LEN];
    logic        [mrt_pkg::ELEM_W-1:0] col_reg    [mrt_pkg::ROW_LEN];
    logic                              s2_valid_reg;
    logic                              out_valid_reg;

    always_comb
    begin
        for (int j = 0; j < mrt_pkg::ROW_LEN; j++)
        begin
            sum_a_next[j] = mrt_pkg::PSUM_W'($signed(lane_prod[0][j]))
                          + mrt_pkg::PSUM_W'($signed(lane_prod[1][j]));
            sum_b_next[j] = mrt_pkg::PSUM_W'($signed(lane_prod[2][j]))
                          + mrt_pkg::PSUM_W'($signed(lane_prod[3][j]));
        end
    end

    // floor shift, then clamp to the signed 32-bit range
    always_comb
    begin
        for (int j = 0; j < mrt_pkg::ROW_LEN; j++)
        begin
            total[j]   = mrt_pkg::SUM_W'(sum_a_reg[j]) + mrt_pkg::SUM_W'(sum_b_reg[j]);
            shifted[j] = total[j] >>> FRAC_BITS;
            hi_bits[j] = shifted[j][mrt_pkg::SUM_W-1:mrt_pkg::ELEM_W-1];
            if ((&hi_bits[j]) || !(|hi_bits[j]))
            begin
                col_next[j] = shifted[j][mrt_pkg::ELEM_W-1:0];
            end
            else if (shifted[j][mrt_pkg::SUM_W-1])
            begin
                col_next[j] = {1'b1, {(mrt_pkg::ELEM_W-1){1'b0}}};
            end
            else
            begin
                col_next[j] = {1'b0, {(mrt_pkg::ELEM_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            for (int j = 0; j < mrt_pkg::ROW_LEN; j++)
            begin
                sum_a_reg[j] <= sum_a_next[j];
                sum_b_reg[j] <= sum_b_next[j];
                col_reg[j]   <= col_next[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            s2_valid_reg  <= ctrl.valid;
            out_valid_reg <= s2_valid_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign row_out.row_out_0 = col_reg[0];
    assign row_out.row_out_1 = col_reg[1];
    assign row_out.row_out_2 = col_reg[2];
    assign row_out.row_out_3 = col_reg[3];

endmodule

`default_nettype wire

// ===== src/matrix4_row_transform_unit.sv =====
// ----------------------------------------------------------------------------
// matrix4_row_transform_unit
// Row of A times the 4x4 matrix B held in eight coefficient registers,
// signed fixed point with saturation.
//
//   channel   signals                          direction
//   input     in_valid, in_ready, row_in       in
//   output    out_valid, out_ready, row_out    out
//   config    cfg_wr_en, cfg_index, cfg_data   in
//
// one item per cycle unless the output item waits, three register stages
// stage 1: four lanes of four multipliers, stage 2 and 3: column sums,
// floor shift and saturation into the output register
// the whole pipeline holds while the output item waits
// reset loads the identity matrix and empties the pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module matrix4_row_transform_unit
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire mrt_pkg::row_in_t                  row_in,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output mrt_pkg::row_out_t                      row_out,
    input  wire logic                              cfg_wr_en,
    input  wire logic [mrt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mrt_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [mrt_pkg::PAIR_W-1:0]        coef_reg [mrt_pkg::NUM_PAIRS];
    logic signed [mrt_pkg::ELEM_W-1:0] elem     [mrt_pkg::ROW_LEN];
    mrt_pkg::prod_vec_t                lane_prod [mrt_pkg::ROW_LEN];
    mrt_pkg::mrt_ctrl_t                ctrl;
    logic                              s1_valid_reg;
    logic                              advance;

    // identity matrix: a one on every diagonal element
    function automatic logic [mrt_pkg::PAIR_W-1:0] reset_pair(input int k);
        logic [mrt_pkg::PAIR_W-1:0] v;
        int e;
        v = '0;
        for (int r = 0; r < mrt_pkg::ROW_LEN; r++)
        begin
            e = r * mrt_pkg::ROW_LEN + r;
            if ((e / 2) == k)
            begin
                v[(e % 2) * mrt_pkg::ELEM_W + FRAC_BITS] = 1'b1;
            end
        end
        return v;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < mrt_pkg::NUM_PAIRS; k++)
            begin
                coef_reg[k] <= reset_pair(k);
            end
        end
        else if (cfg_wr_en)
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    assign elem[0] = row_in.row_in_0;
    assign elem[1] = row_in.row_in_1;
    assign elem[2] = row_in.row_in_2;
    assign elem[3] = row_in.row_in_3;

    for (genvar i = 0; i < mrt_pkg::ROW_LEN; i++)
    begin : g_lane
        mrt_lane u_lane
        (
            .clk      (clk),
            .advance  (advance),
            .elem     (elem[i]),
            .coef_row ({coef_reg[2*i+1], coef_reg[2*i]}),
            .prod     (lane_prod[i])
        );
    end

    assign ctrl.advance = advance;
    assign ctrl.valid   = s1_valid_reg;

    mrt_merge
    #(
        .FRAC_BITS (FRAC_BITS)
    )
    u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .lane_prod (lane_prod),
        .out_valid (out_valid),
        .row_out   (row_out)
    );

endmodule

`default_nettype wire
